/* sv/minmax_normalize_u16_to_u8_top_defines.svh */
// Assertion macros used by the file that checks this block.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef MINMAX_NORMALIZE_U16_TO_U8_TOP_DEFINES_SVH
`define MINMAX_NORMALIZE_U16_TO_U8_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MMN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmn check failed");

// Next-cycle implication, checked out of reset.
`define MMN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmn check failed");

`endif

/* sv/mmn_pkg.sv */
package mmn_pkg;

	// Width of the sample field on the port.
	localparam int SAMPLE_W = 16;
	// Bits of the sample that take part in the stretch.
	localparam int SAMPLE_BITS = 16;
	// Width of the output byte and of the quotient.
	localparam int PIX_W = 8;
	// Numerator (diff*510 + range) and denominator (2*range) widths.
	localparam int NUM_W = SAMPLE_BITS + 9;
	localparam int DEN_W = SAMPLE_BITS + 1;
	// Divider step counter.
	localparam int CNT_W = $clog2(PIX_W);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic measure;
		logic load;
		logic prep;
		logic step;
		logic finish;
	} mmn_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bypass;
	} mmn_stat_t;

endpackage

/* sv/mmn_in_if.sv */
interface mmn_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [mmn_pkg::SAMPLE_W-1:0] sample;
	logic                       last;

	modport source (output valid, kind, sample, last, input ready);
	modport sink (input valid, kind, sample, last, output ready);
endinterface

/* sv/mmn_out_if.sv */
interface mmn_out_if;
	logic                      valid;
	logic                      ready;
	logic [mmn_pkg::PIX_W-1:0] pixel_out;
	logic                      last_out;

	modport source (output valid, pixel_out, last_out, input ready);
	modport sink (input valid, pixel_out, last_out, output ready);
endinterface

/* sv/mmn_ctrl.sv */
module mmn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mmn_pkg::mmn_stat_t stat,
	output mmn_pkg::mmn_cmd_t  cmd
);
	import mmn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Commands for the datapath, decoded from the state and the input and output handshakes.
	always_comb begin
		cmd         = '0;
		cmd.measure = accept && !in_kind;
		cmd.load    = accept && in_kind;
		cmd.prep    = (state_q == S_PREP);
		cmd.step    = (state_q == S_DIV);
		cmd.finish  = (state_q == S_DONE) && out_free;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_kind) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				state_d = stat.bypass ? S_DONE : S_DIV;
			end
			S_DIV: begin
				if (cnt_q == CNT_W'(PIX_W - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, divider step count and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* sv/mmn_dp.sv */
module mmn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mmn_pkg::mmn_cmd_t            cmd,
	output mmn_pkg::mmn_stat_t           stat,
	input  logic [mmn_pkg::SAMPLE_W-1:0] sample,
	input  logic                         last,
	output logic [mmn_pkg::PIX_W-1:0]    pixel_out,
	output logic                         last_out
);
	import mmn_pkg::*;

	logic [SAMPLE_BITS-1:0] lowest_q;
	logic [SAMPLE_BITS-1:0] highest_q;
	logic                   started_q;
	logic [SAMPLE_BITS-1:0] x_in;
	logic [SAMPLE_BITS-1:0] x_q;
	logic                   last_q;
	logic [DEN_W-1:0]       rem_q;
	logic [PIX_W-1:0]       num_lo_q;
	logic [DEN_W-1:0]       den_q;
	logic [PIX_W-1:0]       quot_q;
	logic [PIX_W-1:0]       pixel_q;
	logic                   last_out_q;

	logic                   zero_res;
	logic                   sat_res;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SAMPLE_BITS-1:0] range;
	logic [NUM_W-1:0]       diff_ext;
	logic [NUM_W-1:0]       num;
	logic [DEN_W:0]         trial;
	logic [DEN_W:0]         trial_sub;
	logic                   qbit;

	assign x_in = sample[SAMPLE_BITS-1:0];

	// Special results: empty range or sample at or below the minimum give 0,
	// sample at or above the maximum saturates.
	assign zero_res    = (highest_q <= lowest_q) || (x_q <= lowest_q);
	assign sat_res     = !zero_res && (x_q >= highest_q);
	assign stat.bypass = zero_res || sat_res;

	// Numerator diff*510 + range, built from two shifts.
	assign diff     = x_q - lowest_q;
	assign range    = highest_q - lowest_q;
	assign diff_ext = NUM_W'(diff);
	assign num      = (diff_ext << 9) - (diff_ext << 1) + NUM_W'(range);

	// One restoring step: bring in the next numerator bit and try a subtract.
	assign trial     = {rem_q, num_lo_q[PIX_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign qbit      = (trial >= {1'b0, den_q});

	// Running minimum and maximum with pass tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= '0;
			highest_q <= '0;
			started_q <= 1'b0;
		end else if (cmd.measure) begin
			if (!started_q) begin
				lowest_q  <= x_in;
				highest_q <= x_in;
			end else begin
				if (x_in < lowest_q) begin
					lowest_q <= x_in;
				end
				if (x_in > highest_q) begin
					highest_q <= x_in;
				end
			end
			started_q <= !last;
		end else if (cmd.load) begin
			started_q <= 1'b0;
		end
	end

	// Convert word capture, divider and output word register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_in;
			last_q <= last;
		end
		if (cmd.prep) begin
			rem_q    <= num[NUM_W-1:PIX_W];
			num_lo_q <= num[PIX_W-1:0];
			den_q    <= {range, 1'b0};
			quot_q   <= sat_res ? '1 : '0;
		end else if (cmd.step) begin
			rem_q    <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			num_lo_q <= {num_lo_q[PIX_W-2:0], 1'b0};
			quot_q   <= {quot_q[PIX_W-2:0], qbit};
		end
		if (cmd.finish) begin
			pixel_q    <= quot_q;
			last_out_q <= last_q;
		end
	end

	assign pixel_out = pixel_q;
	assign last_out  = last_out_q;
endmodule

/* sv/minmax_normalize_u16_to_u8_top.sv */
// Measure words (kind 0) are taken one per cycle while the block is idle and give no output word.
// A convert word passes through prep, the 8-step restoring divider and done before its
// output word is registered; a result of 0 or 255 skips the divider. The input is held
// off from a convert word's acceptance until the block is back in idle.
// A waiting output word stalls the input after the next convert word.
// Asynchronous active-low reset clears min, max, pass tracking and control.
`include "minmax_normalize_u16_to_u8_top_defines.svh"

module minmax_normalize_u16_to_u8_top (
	input logic      clk,
	input logic      arst_n,
	mmn_in_if.sink   in_ch,
	mmn_out_if.source out_ch
);
	import mmn_pkg::*;

	mmn_cmd_t  cmd;
	mmn_stat_t stat;

	// Sequencer.
	mmn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_kind   (in_ch.kind),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Min/max tracking, scaling and division.
	mmn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (in_ch.sample),
		.last      (in_ch.last),
		.pixel_out (out_ch.pixel_out),
		.last_out  (out_ch.last_out)
	);

	// A convert word holds off the input until its result is stored.
	`MMN_ASSERT_NEXT(a_conv_busy, in_ch.valid && in_ch.ready && in_ch.kind, !in_ch.ready)
	// A measure word never stalls the input.
	`MMN_ASSERT_NEXT(a_meas_free, in_ch.valid && in_ch.ready && !in_ch.kind, in_ch.ready)
	// The divider only runs while the input is held off.
	`MMN_ASSERT_NOW(a_div_busy, cmd.step, !in_ch.ready)
	// An output word appears only after a finished conversion.
	`MMN_ASSERT_NOW(a_out_src, $rose(out_ch.valid), $past(cmd.finish))
endmodule
